>>> rtl/core/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared widths, register indexes and control types for the windowed
// trapezoid rms block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtr_pkg;

  localparam int DEF_TIME_BITS     = 32;
  localparam int DEF_VALUE_BITS    = 16;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int AREA_W    = 64;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RMS_W     = 24;
  localparam int ROOT_W    = 32;
  localparam int Q_DEPTH   = 4;

  localparam logic [CFG_W-1:0] WIN_START_RST = '0;
  localparam logic [CFG_W-1:0] WIN_END_RST   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 2'd0,
    REG_WINDOW_END   = 2'd1
  } reg_idx_t;

  // back part to divide/root unit
  typedef struct packed {
    logic start;
    logic ack;
  } calc_ctl_t;

  // divide/root unit to back part
  typedef struct packed {
    logic busy;
    logic done;
  } calc_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/wtr_if.sv
// ----------------------------------------------------------------------------
// wtr_if
// Valid/ready channels: sample input, result output and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wtr_sample_if #(
  parameter int TIME_BITS  = wtr_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS = wtr_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         last_sample;

  modport source (output valid, sample_time, sample_value, last_sample, input ready);
  modport sink   (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

interface wtr_result_if;
  logic                       valid;
  logic                       ready;
  logic [wtr_pkg::RMS_W-1:0]  rms_value;
  logic                       status;

  modport source (output valid, rms_value, status, input ready);
  modport sink   (input valid, rms_value, status, output ready);
endinterface

interface wtr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wtr_pkg::CFG_IDX_W-1:0] index;
  logic [wtr_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/windowed_trapezoid_rms.sv
// ----------------------------------------------------------------------------
// windowed_trapezoid_rms
// Windowed trapezoidal rms of a time-ordered sampled waveform.
// ----------------------------------------------------------------------------
// Samples are taken one a cycle for as long as the four-word queue between
// the front part (window test, squares, time step) and the back part
// (step multiply, saturating accumulate) has room; the back part drains one
// word a cycle while it is not waiting on the divide/root unit or on an
// untaken result. A sample marked last produces one result through the
// bit-serial divide (one quotient bit a cycle, 64 + 2*FRACTION_BITS bits)
// and the bit-serial root (one bit a cycle, 32 bits); samples of the next
// waveform keep entering the queue meanwhile, and the back part resumes
// once the result is in the output register. Status 1 with rms_value 0
// means fewer than two samples fell in the window or their span was zero.
`timescale 1ns / 1ps
`default_nettype none

module windowed_trapezoid_rms #(
  parameter int TIME_BITS     = wtr_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS    = wtr_pkg::DEF_VALUE_BITS,
  parameter int FRACTION_BITS = wtr_pkg::DEF_FRACTION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  wtr_sample_if.sink    in_ch,
  wtr_result_if.source  out_ch,
  wtr_cfg_if.sink       cfg_ch
);

  localparam int ENT_W = 2 * VALUE_BITS + 2 * TIME_BITS + 3;

  logic                          push, push_ready, pop, pop_valid;
  logic [ENT_W-1:0]              push_data, pop_data;
  wtr_pkg::calc_ctl_t            calc_ctl;
  wtr_pkg::calc_sts_t            calc_sts;
  logic [wtr_pkg::AREA_W-1:0]    calc_num;
  logic [TIME_BITS:0]            calc_den;
  logic [wtr_pkg::RMS_W-1:0]     calc_root;

  wtr_front #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  wtr_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (wtr_pkg::Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  wtr_calc #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (calc_ctl),
    .sts   (calc_sts),
    .num   (calc_num),
    .den   (calc_den),
    .root  (calc_root)
  );

  wtr_back #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .calc_ctl  (calc_ctl),
    .calc_sts  (calc_sts),
    .calc_num  (calc_num),
    .calc_den  (calc_den),
    .calc_root (calc_root),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/wtr_front.sv
// ----------------------------------------------------------------------------
// wtr_front
// Window registers, window test and per-sample step terms; pushes one
// word per accepted sample into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_front #(
  parameter int TIME_BITS  = wtr_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS = wtr_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  wtr_sample_if.sink                    in_ch,
  wtr_cfg_if.sink                       cfg_ch,
  output logic                          push,
  output logic [2*VALUE_BITS+2*TIME_BITS+2:0] push_data,
  input  logic                          push_ready
);

  localparam int SQ_W  = 2 * VALUE_BITS;
  localparam int WIN_W = (TIME_BITS > wtr_pkg::CFG_W) ? TIME_BITS : wtr_pkg::CFG_W;

  logic [wtr_pkg::CFG_W-1:0] win_start_r, win_end_r;
  logic                      have_first_r;
  logic [TIME_BITS-1:0]      first_time_r, prev_time_r;
  logic [SQ_W-1:0]           prev_sq_r;

  logic [WIN_W-1:0]       t_w;
  logic                   kept;
  logic signed [SQ_W-1:0] sq_s;
  logic [SQ_W-1:0]        cur_sq, sq_sum;
  logic [TIME_BITS-1:0]   step_dt, span;
  logic                   add_step, err;
  logic                   have_first_nxt;
  logic [TIME_BITS-1:0]   first_time_nxt, prev_time_nxt;
  logic [SQ_W-1:0]        prev_sq_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push         = in_ch.valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= wtr_pkg::WIN_START_RST;
      win_end_r   <= wtr_pkg::WIN_END_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        wtr_pkg::REG_WINDOW_START: win_start_r <= cfg_ch.data;
        wtr_pkg::REG_WINDOW_END:   win_end_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t_w  = WIN_W'(in_ch.sample_time);
    kept = (t_w >= WIN_W'(win_start_r)) && (t_w <= WIN_W'(win_end_r));
  end

  // both operands signed, so the product is sign-correct at full width
  assign sq_s   = SQ_W'(in_ch.sample_value) * SQ_W'(in_ch.sample_value);
  assign cur_sq = $unsigned(sq_s);

  always_comb begin
    step_dt  = (in_ch.sample_time > prev_time_r) ? (in_ch.sample_time - prev_time_r) : '0;
    sq_sum   = prev_sq_r + cur_sq;
    add_step = kept && have_first_r;

    have_first_nxt = have_first_r;
    first_time_nxt = first_time_r;
    prev_time_nxt  = prev_time_r;
    prev_sq_nxt    = prev_sq_r;
    if (kept) begin
      if (!have_first_r) begin
        have_first_nxt = 1'b1;
        first_time_nxt = in_ch.sample_time;
      end
      prev_time_nxt = in_ch.sample_time;
      prev_sq_nxt   = cur_sq;
    end

    err  = !have_first_nxt || (prev_time_nxt <= first_time_nxt);
    span = prev_time_nxt - first_time_nxt;
  end

  assign push_data = {sq_sum, step_dt, add_step, in_ch.last_sample, err, span};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      first_time_r <= '0;
      prev_time_r  <= '0;
      prev_sq_r    <= '0;
    end else if (push) begin
      if (in_ch.last_sample) begin
        have_first_r <= 1'b0;
        first_time_r <= '0;
        prev_time_r  <= '0;
        prev_sq_r    <= '0;
      end else begin
        have_first_r <= have_first_nxt;
        first_time_r <= first_time_nxt;
        prev_time_r  <= prev_time_nxt;
        prev_sq_r    <= prev_sq_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wtr_fifo.sv
// ----------------------------------------------------------------------------
// wtr_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wtr_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wtr_calc.sv
// ----------------------------------------------------------------------------
// wtr_calc
// Bit-serial scaled divide followed by a bit-serial integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_calc #(
  parameter int TIME_BITS     = wtr_pkg::DEF_TIME_BITS,
  parameter int FRACTION_BITS = wtr_pkg::DEF_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wtr_pkg::calc_ctl_t          ctl,
  output wtr_pkg::calc_sts_t          sts,
  input  logic [wtr_pkg::AREA_W-1:0]  num,
  input  logic [TIME_BITS:0]          den,
  output logic [wtr_pkg::RMS_W-1:0]   root
);

  localparam int AREA_W = wtr_pkg::AREA_W;
  localparam int ROOT_W = wtr_pkg::ROOT_W;
  localparam int RMS_W  = wtr_pkg::RMS_W;
  localparam int DV_W   = AREA_W + 2 * FRACTION_BITS;
  localparam int DEN_W  = TIME_BITS + 1;
  localparam int REM_W  = TIME_BITS + 2;
  localparam int CNT_W  = $clog2(DV_W);
  localparam int SR_W   = ROOT_W + 2;
  localparam int SSH_W  = ROOT_W + 4;

  typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT, U_DONE} ustate_t;

  ustate_t           state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DV_W-1:0]   dvd_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [AREA_W-1:0] rad_r;
  logic [SR_W-1:0]   srem_r;
  logic [ROOT_W-1:0] sroot_r;
  logic [RMS_W-1:0]  root_r;

  logic [REM_W-1:0]  rem_sh;
  logic              q_bit;
  logic [DV_W:0]     q_x;
  logic [AREA_W-1:0] q_sat;
  logic [SSH_W-1:0]  srem_sh, trial;
  logic              r_bit;
  logic [ROOT_W-1:0] sroot_nxt;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], dvd_r[DV_W-1]};
    q_bit  = (rem_sh >= REM_W'(den_r));
    q_x    = (DV_W + 1)'({dvd_r[DV_W-2:0], q_bit});
    q_sat  = (|q_x[DV_W:AREA_W]) ? '1 : q_x[AREA_W-1:0];
  end

  // one root bit per cycle, two radicand bits in
  always_comb begin
    srem_sh   = {srem_r, rad_r[AREA_W-1:AREA_W-2]};
    trial     = SSH_W'({sroot_r, 2'b01});
    r_bit     = (srem_sh >= trial);
    sroot_nxt = {sroot_r[ROOT_W-2:0], r_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        U_IDLE: begin
          if (ctl.start) begin
            dvd_r   <= DV_W'(num) << (2 * FRACTION_BITS);
            rem_r   <= '0;
            den_r   <= den;
            cnt_r   <= CNT_W'(DV_W - 1);
            state_r <= U_DIV;
          end
        end
        U_DIV: begin
          rem_r <= q_bit ? (rem_sh - REM_W'(den_r)) : rem_sh;
          dvd_r <= {dvd_r[DV_W-2:0], q_bit};
          if (cnt_r == '0) begin
            rad_r   <= q_sat;
            srem_r  <= '0;
            sroot_r <= '0;
            cnt_r   <= CNT_W'(ROOT_W - 1);
            state_r <= U_SQRT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        U_SQRT: begin
          srem_r  <= SR_W'(r_bit ? (srem_sh - trial) : srem_sh);
          sroot_r <= sroot_nxt;
          rad_r   <= {rad_r[AREA_W-3:0], 2'b00};
          if (cnt_r == '0) begin
            root_r  <= (|sroot_nxt[ROOT_W-1:RMS_W]) ? '1 : sroot_nxt[RMS_W-1:0];
            state_r <= U_DONE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        U_DONE: begin
          if (ctl.ack) begin
            state_r <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign sts.busy = (state_r != U_IDLE);
  assign sts.done = (state_r == U_DONE);
  assign root     = root_r;

endmodule

`default_nettype wire

>>> rtl/core/wtr_back.sv
// ----------------------------------------------------------------------------
// wtr_back
// Step multiply, saturating area accumulate, result hand-off to the
// divide/root unit and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_back #(
  parameter int TIME_BITS  = wtr_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS = wtr_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  input  logic [2*VALUE_BITS+2*TIME_BITS+2:0] pop_data,
  output logic                               pop,
  output wtr_pkg::calc_ctl_t                 calc_ctl,
  input  wtr_pkg::calc_sts_t                 calc_sts,
  output logic [wtr_pkg::AREA_W-1:0]         calc_num,
  output logic [TIME_BITS:0]                 calc_den,
  input  logic [wtr_pkg::RMS_W-1:0]          calc_root,
  wtr_result_if.source                       out_ch
);

  localparam int AREA_W = wtr_pkg::AREA_W;
  localparam int SQ_W   = 2 * VALUE_BITS;
  localparam int PW     = SQ_W + TIME_BITS;
  localparam int EXT_W  = (PW > AREA_W) ? PW : AREA_W + 1;

  typedef enum logic {B_RUN, B_CALC} bstate_t;

  logic [SQ_W-1:0]      e_sq;
  logic [TIME_BITS-1:0] e_dt, e_span;
  logic                 e_add, e_last, e_err;

  logic [PW-1:0]     prod;
  logic [EXT_W-1:0]  prod_x;
  logic [AREA_W-1:0] prod_sat;

  logic                 m_valid_r, m_add_r, m_last_r, m_err_r;
  logic [AREA_W-1:0]    m_prod_r;
  logic [TIME_BITS-1:0] m_span_r;

  bstate_t             state_r;
  logic [AREA_W-1:0]   area_r;
  logic [AREA_W:0]     area_sum;
  logic [AREA_W-1:0]   area_nxt;
  logic                calc_start_r;
  logic [AREA_W-1:0]   calc_num_r;
  logic [TIME_BITS:0]  calc_den_r;
  logic                out_valid_r, status_r;
  logic [wtr_pkg::RMS_W-1:0] rms_r;

  logic out_busy, m_take, calc_ack, out_set;

  assign {e_sq, e_dt, e_add, e_last, e_err, e_span} = pop_data;

  // step area, saturated to the area width
  always_comb begin
    prod     = PW'(e_sq) * PW'(e_dt);
    prod_x   = EXT_W'(prod);
    prod_sat = (|prod_x[EXT_W-1:AREA_W]) ? '1 : prod_x[AREA_W-1:0];
  end

  assign out_busy = out_valid_r && !out_ch.ready;
  assign m_take   = (state_r == B_RUN) && m_valid_r && (!m_last_r || !out_busy);
  assign pop      = pop_valid && (!m_valid_r || m_take);
  assign calc_ack = (state_r == B_CALC) && calc_sts.done && !out_busy;
  // a result word enters the output register
  assign out_set  = (m_take && m_last_r && m_err_r) || calc_ack;

  always_comb begin
    area_sum = {1'b0, area_r} + {1'b0, (m_add_r ? m_prod_r : {AREA_W{1'b0}})};
    area_nxt = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod_r <= prod_sat;
      m_add_r  <= e_add;
      m_last_r <= e_last;
      m_err_r  <= e_err;
      m_span_r <= e_span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      area_r    <= '0;
    end else begin
      if (pop) begin
        m_valid_r <= 1'b1;
      end else if (m_take) begin
        m_valid_r <= 1'b0;
      end
      if (m_take) begin
        area_r <= m_last_r ? '0 : area_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_RUN;
      calc_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      status_r     <= 1'b0;
      rms_r        <= '0;
    end else begin
      calc_start_r <= m_take && m_last_r && !m_err_r;
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_RUN: begin
          if (m_take && m_last_r) begin
            if (m_err_r) begin
              rms_r    <= '0;
              status_r <= 1'b1;
            end else begin
              calc_num_r <= area_nxt;
              calc_den_r <= {m_span_r, 1'b0};
              state_r    <= B_CALC;
            end
          end
        end
        B_CALC: begin
          if (calc_ack) begin
            rms_r    <= calc_root;
            status_r <= 1'b0;
            state_r  <= B_RUN;
          end
        end
        default: state_r <= B_RUN;
      endcase
    end
  end

  assign calc_ctl.start   = calc_start_r;
  assign calc_ctl.ack     = calc_ack;
  assign calc_num         = calc_num_r;
  assign calc_den         = calc_den_r;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.rms_value = rms_r;
  assign out_ch.status    = status_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    calc_ctl.start |-> !calc_sts.busy)
    else $error("divide started while unit busy");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (m_take && m_last_r && !m_err_r) |=> calc_ctl.start)
    else $error("good last word did not start the divide");

  a_area_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (m_take && m_last_r) |=> (area_r == '0))
    else $error("area not cleared after last word");
`endif

endmodule

`default_nettype wire
